// ----- hw/rtl/wria_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wria_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int REG_WIDTH       = 32;

    localparam logic signed [REG_WIDTH-1:0] BOUND_A_RESET = 32'sd0;
    localparam logic signed [REG_WIDTH-1:0] BOUND_B_RESET = 32'sd11;

    localparam logic CFG_BOUND_A = 1'b0;
    localparam logic CFG_BOUND_B = 1'b1;

    typedef enum logic [4:0] {
        OP_LOAD = 5'd0,
        OP_ADD  = 5'd1,
        OP_SUB  = 5'd2,
        OP_RSUB = 5'd3,
        OP_MUL  = 5'd4,
        OP_DIV  = 5'd5,
        OP_RDIV = 5'd6,
        OP_MOD  = 5'd7,
        OP_RMOD = 5'd8,
        OP_XOR  = 5'd9,
        OP_AND  = 5'd10,
        OP_OR   = 5'd11,
        OP_SHL  = 5'd12,
        OP_SHR  = 5'd13,
        OP_RSHL = 5'd14,
        OP_RSHR = 5'd15,
        OP_NOT  = 5'd16,
        OP_NEG  = 5'd17,
        OP_INC  = 5'd18,
        OP_DEC  = 5'd19,
        OP_CMP  = 5'd20
    } opcode_t;

    // divider operand selection; the code also picks where the result is latched (DS_WRAP latches nothing)
    typedef enum logic [3:0] {
        DS_WRAP,
        DS_TRUNC,
        DS_A,
        DS_B,
        DS_EUC,
        DS_BG,
        DS_M2,
        DS_TM,
        DS_X0,
        DS_X
    } div_sel_t;

    typedef enum logic [1:0] {
        K_ERR,
        K_WRAP,
        K_TRUNC,
        K_SEARCH
    } kind_t;

    typedef struct packed {
        logic [4:0]         opcode;
        logic signed [31:0] operand;
        logic               write_back;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic signed [31:0] previous_value;
        logic               op_error;
        logic               is_less;
        logic               is_equal;
    } out_word_t;

    typedef struct packed {
        logic     capture;
        logic     exec;
        logic     div_start;
        div_sel_t div_sel;
        logic     latch;
        logic     euc_mul;
        logic     euc_upd;
        logic     pmul;
        logic     set_err;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  div_done;
        logic  r1_zero;
        logic  bg_fail;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wria_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wria_div #(
    parameter int DW = 66,
    parameter int NW = 33
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [DW-1:0] dividend,
    input  wire logic [NW-1:0]        divisor,
    output logic                      done,
    output logic [DW-1:0]             quotient,
    output logic [NW-1:0]             remainder,
    output logic [NW-1:0]             floor_rem
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] q_reg;
    logic [NW-1:0] r_reg;
    logic [NW-1:0] d_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;

    logic [DW-1:0] mag;
    logic [NW:0]   shifted;
    logic [NW:0]   diff;
    logic          fits;
    logic [NW-1:0] r_next;

    assign mag     = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
    assign shifted = {r_reg, q_reg[DW-1]};
    assign diff    = shifted - {1'b0, d_reg};
    assign fits    = shifted >= {1'b0, d_reg};
    assign r_next  = fits ? diff[NW-1:0] : shifted[NW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(DW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CW'(1);
            done_reg <= (cnt_reg == CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= mag;
            r_reg   <= '0;
            d_reg   <= divisor;
            neg_reg <= dividend[DW-1];
        end
        else if (cnt_reg != '0)
        begin
            q_reg <= {q_reg[DW-2:0], fits};
            r_reg <= r_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign floor_rem = (neg_reg && r_reg != '0) ? d_reg - r_reg : r_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/wria_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wria_dp #(
    parameter int W = wria_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic                       cfg_index,
    input  wire logic [wria_pkg::REG_WIDTH-1:0] cfg_data,
    input  wire wria_pkg::in_word_t         in_word,
    output wria_pkg::out_word_t             out_word,
    input  wire wria_pkg::dp_cmd_t          cmd,
    output wria_pkg::dp_stat_t              stat
);

    localparam int NW = W + 1;
    localparam int TW = W + 2;
    localparam int DW = 2 * W + 2;
    localparam int PW = NW + 1 + TW;
    localparam int AW = $clog2(W);
    localparam logic [W-2:0] SH_MAX = (W-1)'(W - 1);
    localparam logic signed [W-1:0] A_RST = wria_pkg::BOUND_A_RESET[W-1:0];
    localparam logic signed [W-1:0] B_RST = wria_pkg::BOUND_B_RESET[W-1:0];
    localparam logic signed [W-1:0] HELD_RST = (A_RST < B_RST) ? A_RST : B_RST;

    logic signed [W-1:0]  bound_a_reg, bound_b_reg, held_reg, opnd_reg;
    wria_pkg::opcode_t    op_reg;
    logic                 wb_reg, err_reg;
    logic signed [DW-1:0] v_reg;
    logic [NW-1:0]        r0_reg, r1_reg, q_reg, b_reg, bg_reg, m2_reg, tm_reg, x0_reg;
    logic signed [TW-1:0] t0_reg, t1_reg;
    logic signed [PW-1:0] prod_reg;
    logic [DW-1:0]        p_reg;
    wria_pkg::out_word_t  out_reg;

    logic signed [W-1:0]  lo, hi, target, mulsrc, amt_src, dd, dv, wrap_w;
    logic [NW-1:0]        n, dv_abs;
    logic signed [NW-1:0] dv_x;
    logic signed [DW-1:0] s_d, o_d, v_exec, div_d;
    logic [NW-1:0]        div_n;
    logic signed [2*W-1:0] mul_p;
    logic [AW-1:0]        amt;
    logic                 amt_bad, is_mod;
    logic                 div_done;
    logic [DW-1:0]        div_q;
    logic [NW-1:0]        div_r, div_f;
    logic signed [DW-1:0] trunc_v;
    wria_pkg::kind_t      kind_c;

    assign lo = (bound_a_reg < bound_b_reg) ? bound_a_reg : bound_b_reg;
    assign hi = (bound_a_reg < bound_b_reg) ? bound_b_reg : bound_a_reg;
    assign n  = {hi[W-1], hi} - {lo[W-1], lo} + NW'(1);

    assign s_d   = DW'(held_reg);
    assign o_d   = DW'(opnd_reg);
    assign mul_p = held_reg * opnd_reg;

    assign is_mod  = (op_reg == wria_pkg::OP_MOD);
    assign dd      = is_mod ? held_reg : opnd_reg;
    assign dv      = is_mod ? opnd_reg : held_reg;
    assign dv_x    = NW'(dv);
    assign dv_abs  = dv_x[NW-1] ? NW'(-dv_x) : NW'(dv_x);
    assign target  = (op_reg == wria_pkg::OP_DIV) ? held_reg : opnd_reg;
    assign mulsrc  = (op_reg == wria_pkg::OP_DIV) ? opnd_reg : held_reg;

    assign amt_src = (op_reg == wria_pkg::OP_SHL || op_reg == wria_pkg::OP_SHR)
                     ? opnd_reg : held_reg;
    assign amt_bad = amt_src[W-1] || (amt_src[W-2:0] > SH_MAX);
    assign amt     = amt_src[AW-1:0];

    always_comb
    begin
        v_exec = s_d;
        kind_c = wria_pkg::K_WRAP;
        case (op_reg)
            wria_pkg::OP_LOAD: v_exec = o_d;
            wria_pkg::OP_ADD:  v_exec = s_d + o_d;
            wria_pkg::OP_SUB:  v_exec = s_d - o_d;
            wria_pkg::OP_RSUB: v_exec = o_d - s_d;
            wria_pkg::OP_MUL:  v_exec = DW'(mul_p);
            wria_pkg::OP_DIV, wria_pkg::OP_RDIV:
            begin
                kind_c = (target < lo || target > hi) ? wria_pkg::K_ERR
                                                       : wria_pkg::K_SEARCH;
            end
            wria_pkg::OP_MOD, wria_pkg::OP_RMOD:
            begin
                kind_c = (dv == '0) ? wria_pkg::K_ERR : wria_pkg::K_TRUNC;
            end
            wria_pkg::OP_XOR:  v_exec = DW'(held_reg ^ opnd_reg);
            wria_pkg::OP_AND:  v_exec = DW'(held_reg & opnd_reg);
            wria_pkg::OP_OR:   v_exec = DW'(held_reg | opnd_reg);
            wria_pkg::OP_SHL:  v_exec = s_d <<< amt;
            wria_pkg::OP_SHR:  v_exec = s_d >>> amt;
            wria_pkg::OP_RSHL: v_exec = o_d <<< amt;
            wria_pkg::OP_RSHR: v_exec = o_d >>> amt;
            wria_pkg::OP_NOT:  v_exec = DW'(~held_reg);
            wria_pkg::OP_NEG:  v_exec = DW'(hi) - s_d;
            wria_pkg::OP_INC:  v_exec = s_d + DW'(1);
            wria_pkg::OP_DEC:  v_exec = s_d - DW'(1);
            wria_pkg::OP_CMP:  v_exec = s_d;
            default:           kind_c = wria_pkg::K_ERR;
        endcase
        if ((op_reg == wria_pkg::OP_SHL || op_reg == wria_pkg::OP_SHR ||
             op_reg == wria_pkg::OP_RSHL || op_reg == wria_pkg::OP_RSHR) && amt_bad)
        begin
            kind_c = wria_pkg::K_ERR;
        end
    end

    always_comb
    begin
        div_d = '0;
        div_n = n;
        case (cmd.div_sel)
            wria_pkg::DS_WRAP:  div_d = v_reg - DW'(lo);
            wria_pkg::DS_TRUNC:
            begin
                div_d = DW'(dd);
                div_n = dv_abs;
            end
            wria_pkg::DS_A:     div_d = DW'(mulsrc);
            wria_pkg::DS_B:     div_d = DW'(target);
            wria_pkg::DS_EUC:
            begin
                div_d = DW'(r0_reg);
                div_n = r1_reg;
            end
            wria_pkg::DS_BG:
            begin
                div_d = DW'(b_reg);
                div_n = r0_reg;
            end
            wria_pkg::DS_M2:
            begin
                div_d = DW'(n);
                div_n = r0_reg;
            end
            wria_pkg::DS_TM:
            begin
                div_d = DW'(t0_reg);
                div_n = m2_reg;
            end
            wria_pkg::DS_X0:
            begin
                div_d = signed'(p_reg);
                div_n = m2_reg;
            end
            wria_pkg::DS_X:
            begin
                div_d = DW'(x0_reg) - DW'(lo);
                div_n = m2_reg;
            end
            default:
            begin
                div_d = '0;
                div_n = n;
            end
        endcase
    end

    wria_div #(
        .DW(DW),
        .NW(NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_d),
        .divisor  (div_n),
        .done     (div_done),
        .quotient (div_q),
        .remainder(div_r),
        .floor_rem(div_f)
    );

    assign wrap_w  = lo + div_f[W-1:0];
    assign trunc_v = div_d[DW-1] ? DW'(0) - DW'(div_r) : DW'(div_r);

    assign stat.kind     = kind_c;
    assign stat.div_done = div_done;
    assign stat.r1_zero  = (r1_reg == '0);
    assign stat.bg_fail  = (div_r != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_a_reg <= A_RST;
            bound_b_reg <= B_RST;
            held_reg    <= HELD_RST;
            err_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && cfg_index == wria_pkg::CFG_BOUND_A)
            begin
                bound_a_reg <= cfg_data[W-1:0];
            end
            if (cfg_wr_en && cfg_index == wria_pkg::CFG_BOUND_B)
            begin
                bound_b_reg <= cfg_data[W-1:0];
            end
            if (cmd.capture)
            begin
                err_reg <= 1'b0;
            end
            else if (cmd.set_err)
            begin
                err_reg <= 1'b1;
            end
            if (cmd.finish && !err_reg && wb_reg)
            begin
                held_reg <= wrap_w;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= wria_pkg::opcode_t'(in_word.opcode);
            opnd_reg <= in_word.operand[W-1:0];
            wb_reg   <= in_word.write_back;
        end
        if (cmd.exec)
        begin
            v_reg <= v_exec;
        end
        if (cmd.latch)
        begin
            case (cmd.div_sel)
                wria_pkg::DS_TRUNC: v_reg <= trunc_v;
                wria_pkg::DS_A:
                begin
                    r0_reg <= n;
                    r1_reg <= div_f;
                    t0_reg <= '0;
                    t1_reg <= TW'(1);
                end
                wria_pkg::DS_B:  b_reg  <= div_f;
                wria_pkg::DS_EUC:
                begin
                    q_reg  <= div_q[NW-1:0];
                    r0_reg <= r1_reg;
                    r1_reg <= div_r;
                end
                wria_pkg::DS_BG: bg_reg <= div_q[NW-1:0];
                wria_pkg::DS_M2: m2_reg <= div_q[NW-1:0];
                wria_pkg::DS_TM: tm_reg <= div_f;
                wria_pkg::DS_X0: x0_reg <= div_f;
                wria_pkg::DS_X:  v_reg  <= DW'(wrap_w);
                default:         ;
            endcase
        end
        if (cmd.euc_mul)
        begin
            prod_reg <= signed'({1'b0, q_reg}) * t1_reg;
        end
        if (cmd.euc_upd)
        begin
            t0_reg <= t1_reg;
            t1_reg <= t0_reg - signed'(prod_reg[TW-1:0]);
        end
        if (cmd.pmul)
        begin
            p_reg <= bg_reg * tm_reg;
        end
        if (cmd.finish)
        begin
            out_reg.result_value   <= err_reg ? 32'(held_reg) : 32'(wrap_w);
            out_reg.previous_value <= 32'(held_reg);
            out_reg.op_error       <= err_reg;
            out_reg.is_less        <= held_reg < opnd_reg;
            out_reg.is_equal       <= held_reg == opnd_reg;
        end
    end

    assign out_word = out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/wria_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wria_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output wria_pkg::dp_cmd_t      cmd,
    input  wire wria_pkg::dp_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_ECHK,
        S_EMUL,
        S_EUPD,
        S_PMUL,
        S_FIN,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    wria_pkg::div_sel_t sel_reg, sel_next;
    logic               start_reg, start_next;
    logic               div_fin;

    assign div_fin = (state_reg == S_DIV) && stat.div_done;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        start_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.kind)
                    wria_pkg::K_WRAP:
                    begin
                        state_next = S_DIV;
                        sel_next   = wria_pkg::DS_WRAP;
                        start_next = 1'b1;
                    end
                    wria_pkg::K_TRUNC:
                    begin
                        state_next = S_DIV;
                        sel_next   = wria_pkg::DS_TRUNC;
                        start_next = 1'b1;
                    end
                    wria_pkg::K_SEARCH:
                    begin
                        state_next = S_DIV;
                        sel_next   = wria_pkg::DS_A;
                        start_next = 1'b1;
                    end
                    default: state_next = S_FIN;
                endcase
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_DIV;
                    start_next = 1'b1;
                    case (sel_reg)
                        wria_pkg::DS_TRUNC: sel_next = wria_pkg::DS_WRAP;
                        wria_pkg::DS_A:     sel_next = wria_pkg::DS_B;
                        wria_pkg::DS_B:
                        begin
                            state_next = S_ECHK;
                            start_next = 1'b0;
                        end
                        wria_pkg::DS_EUC:
                        begin
                            state_next = S_EMUL;
                            start_next = 1'b0;
                        end
                        wria_pkg::DS_BG:
                        begin
                            if (stat.bg_fail)
                            begin
                                state_next = S_FIN;
                                start_next = 1'b0;
                            end
                            else
                            begin
                                sel_next = wria_pkg::DS_M2;
                            end
                        end
                        wria_pkg::DS_M2:    sel_next = wria_pkg::DS_TM;
                        wria_pkg::DS_TM:
                        begin
                            state_next = S_PMUL;
                            start_next = 1'b0;
                        end
                        wria_pkg::DS_X0:    sel_next = wria_pkg::DS_X;
                        wria_pkg::DS_X:     sel_next = wria_pkg::DS_WRAP;
                        default:
                        begin
                            state_next = S_FIN;
                            start_next = 1'b0;
                        end
                    endcase
                end
            end
            S_ECHK:
            begin
                state_next = S_DIV;
                start_next = 1'b1;
                sel_next   = stat.r1_zero ? wria_pkg::DS_BG : wria_pkg::DS_EUC;
            end
            S_EMUL: state_next = S_EUPD;
            S_EUPD: state_next = S_ECHK;
            S_PMUL:
            begin
                state_next = S_DIV;
                sel_next   = wria_pkg::DS_X0;
                start_next = 1'b1;
            end
            S_FIN:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= wria_pkg::DS_WRAP;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            start_reg <= start_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    assign cmd.capture   = (state_reg == S_IDLE) && in_valid;
    assign cmd.exec      = (state_reg == S_EXEC);
    assign cmd.div_start = start_reg;
    assign cmd.div_sel   = sel_reg;
    assign cmd.latch     = div_fin;
    assign cmd.euc_mul   = (state_reg == S_EMUL);
    assign cmd.euc_upd   = (state_reg == S_EUPD);
    assign cmd.pmul      = (state_reg == S_PMUL);
    assign cmd.set_err   = ((state_reg == S_EXEC) && stat.kind == wria_pkg::K_ERR) ||
                           (div_fin && sel_reg == wria_pkg::DS_BG && stat.bg_fail);
    assign cmd.finish    = (state_reg == S_FIN);

`ifndef SYNTHESIS
    a_start_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> state_reg == S_DIV)
        else $error("divider start outside division state");

    a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |=> state_reg == S_OUT)
        else $error("finish not followed by output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_ready) |=> state_reg == S_OUT)
        else $error("result dropped while stalled");

    a_latch_not_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |-> !start_reg)
        else $error("divider result taken in its start cycle");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/wrapped_range_integer_alu_top.sv -----
// Wrapped-range integer ALU: one signed value held inside [low, high].
// Input channel (in_valid/in_ready/in_word) takes one word: opcode,
// operand and write_back. Output channel (out_valid/out_ready/out_word)
// returns one word per input: wrapped result, previous value, error and
// compare flags. Config port (cfg_wr_en/cfg_index/cfg_data) writes bound_a
// (index 0) or bound_b (index 1); write only while idle.
// One word is in flight at a time. Each divider pass is a bit-serial
// restoring divide of 2*VALUE_WIDTH+2 steps.
// Plain ops: the word is captured, executed, wrapped by one divider pass and
// presented; the next word can be taken in the cycle after the result leaves.
// Remainder ops add one pass. Ops that fail at the execute step skip the
// divider. Division ops run extended Euclid on the same divider.
// Reset loads bound_a = 0, bound_b = 11 and the held value with the lower
// bound. When the receiver stalls, the result holds on out_word and no new
// input word is taken until it is accepted.
`timescale 1ns / 1ps
`default_nettype none

module wrapped_range_integer_alu_top #(
    parameter int VALUE_WIDTH = wria_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire wria_pkg::in_word_t             in_word,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output wria_pkg::out_word_t                 out_word,
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_index,
    input  wire logic [wria_pkg::REG_WIDTH-1:0] cfg_data
);

    wria_pkg::dp_cmd_t  cmd;
    wria_pkg::dp_stat_t stat;

    wria_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    wria_dp #(
        .W(VALUE_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_word  (in_word),
        .out_word (out_word),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    class wrap_alu_model;
        longint    bound_a;
        longint    bound_b;
        longint    held;
        int        mismatches;
        wria_pkg::out_word_t pending_words[$];

        function new();
            bound_a    = wria_pkg::BOUND_A_RESET;
            bound_b    = wria_pkg::BOUND_B_RESET;
            held       = 0;
            mismatches = 0;
        endfunction

        function void set_bound(logic idx, logic signed [31:0] data);
            if (idx == wria_pkg::CFG_BOUND_A)
                bound_a = data;
            else
                bound_b = data;
        endfunction

        static function longint floor_mod(longint d, longint n);
            longint r;
            r = d % n;
            if (r < 0)
                r += n;
            return r;
        endfunction

        // smallest x in [lo, hi] with x*mul congruent to target modulo the range size
        static function bit solve_div(longint lo, longint hi, longint mul, longint target,
                                      output longint x);
            longint n, a, b, u, w, t, g, m2, r0, r1, t0, t1, q, tmp, inv;
            longint unsigned x0;
            x = 0;
            if (target < lo || target > hi)
                return 0;
            n = hi - lo + 1;
            a = floor_mod(mul, n);
            b = floor_mod(target, n);
            u = a;
            w = n;
            while (u != 0)
            begin
                t = w % u;
                w = u;
                u = t;
            end
            g = w;
            if (b % g != 0)
                return 0;
            m2 = n / g;
            inv = 0;
            if (m2 != 1)
            begin
                r0 = m2;
                r1 = a / g;
                t0 = 0;
                t1 = 1;
                while (r1 != 0)
                begin
                    q   = r0 / r1;
                    tmp = r0 - q * r1;
                    r0  = r1;
                    r1  = tmp;
                    tmp = t0 - q * t1;
                    t0  = t1;
                    t1  = tmp;
                end
                inv = floor_mod(t0, m2);
            end
            // the product can pass 2**63; keep it unsigned
            x0 = ($unsigned(b / g) * $unsigned(inv)) % $unsigned(m2);
            x = lo + floor_mod(longint'(x0) - lo, m2);
            return 1;
        endfunction

        function void note_input(wria_pkg::in_word_t w);
            longint    lo, hi, n, s, o, v, base, amt;
            bit        err;
            wria_pkg::out_word_t e;
            lo  = (bound_a < bound_b) ? bound_a : bound_b;
            hi  = (bound_a < bound_b) ? bound_b : bound_a;
            n   = hi - lo + 1;
            s   = held;
            o   = w.operand;
            v   = 0;
            err = 0;
            case (w.opcode)
                wria_pkg::OP_LOAD: v = o;
                wria_pkg::OP_ADD:  v = s + o;
                wria_pkg::OP_SUB:  v = s - o;
                wria_pkg::OP_RSUB: v = o - s;
                wria_pkg::OP_MUL:  v = s * o;
                wria_pkg::OP_DIV:  err = !solve_div(lo, hi, o, s, v);
                wria_pkg::OP_RDIV: err = !solve_div(lo, hi, s, o, v);
                wria_pkg::OP_MOD:  if (o == 0) err = 1; else v = s % o;
                wria_pkg::OP_RMOD: if (s == 0) err = 1; else v = o % s;
                wria_pkg::OP_XOR:  v = s ^ o;
                wria_pkg::OP_AND:  v = s & o;
                wria_pkg::OP_OR:   v = s | o;
                wria_pkg::OP_SHL, wria_pkg::OP_SHR, wria_pkg::OP_RSHL, wria_pkg::OP_RSHR:
                begin
                    base = (w.opcode == wria_pkg::OP_SHL || w.opcode == wria_pkg::OP_SHR)
                           ? s : o;
                    amt  = (w.opcode == wria_pkg::OP_SHL || w.opcode == wria_pkg::OP_SHR)
                           ? o : s;
                    if (amt < 0 || amt >= 32)
                        err = 1;
                    else if (w.opcode == wria_pkg::OP_SHL || w.opcode == wria_pkg::OP_RSHL)
                        v = base * (longint'(1) << amt);
                    else
                        v = base >>> amt;
                end
                wria_pkg::OP_NOT:  v = ~s;
                wria_pkg::OP_NEG:  v = hi - s;
                wria_pkg::OP_INC:  v = s + 1;
                wria_pkg::OP_DEC:  v = s - 1;
                wria_pkg::OP_CMP:  v = s;
                default: err = 1;
            endcase
            e.previous_value = s[31:0];
            e.op_error       = err;
            e.is_less        = (s < o);
            e.is_equal       = (s == o);
            if (err)
                e.result_value = s[31:0];
            else
            begin
                v = lo + floor_mod(v - lo, n);
                e.result_value = v[31:0];
                if (w.write_back)
                    held = v;
            end
            pending_words.push_back(e);
        endfunction

        task flag_mismatch(string what, longint got, longint want);
            mismatches++;
            $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        endtask

        task check_result(wria_pkg::out_word_t got);
            wria_pkg::out_word_t e;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                $display("%0t: result word with nothing pending", $realtime);
                return;
            end
            e = pending_words.pop_front();
            if (got.result_value !== e.result_value)
                flag_mismatch("result_value", got.result_value, e.result_value);
            if (got.previous_value !== e.previous_value)
                flag_mismatch("previous_value", got.previous_value, e.previous_value);
            if (got.op_error !== e.op_error)
                flag_mismatch("op_error", got.op_error, e.op_error);
            if (got.is_less !== e.is_less)
                flag_mismatch("is_less", got.is_less, e.is_less);
            if (got.is_equal !== e.is_equal)
                flag_mismatch("is_equal", got.is_equal, e.is_equal);
        endtask
    endclass

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    wria_pkg::in_word_t  in_word;
    logic            out_valid;
    logic            out_ready;
    wria_pkg::out_word_t out_word;
    logic            cfg_wr_en;
    logic            cfg_index;
    logic [31:0]     cfg_data;

    wrap_alu_model   alu_model;
    int              burst_left;
    int              stall_mode;
    int              cycle_count;

    wrapped_range_integer_alu_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver: drive out_ready in one of four stall styles, picked anew at random
    always @(negedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ((cycle_count % 16) > 11);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            alu_model.check_result(out_word);
    end

    // present one word at a falling edge and hold it until taken
    task automatic send_word(logic [4:0] op, logic signed [31:0] operand, logic wb);
        wria_pkg::in_word_t w;
        w.opcode     = op;
        w.operand    = operand;
        w.write_back = wb;
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        alu_model.note_input(w);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
        end
    endtask

    task automatic write_bounds(logic signed [31:0] a, logic signed [31:0] b);
        in_valid <= 1'b0;
        @(negedge clk);
        while (alu_model.pending_words.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= wria_pkg::CFG_BOUND_A;
        cfg_data  <= a;
        alu_model.set_bound(wria_pkg::CFG_BOUND_A, a);
        @(negedge clk);
        cfg_index <= wria_pkg::CFG_BOUND_B;
        cfg_data  <= b;
        alu_model.set_bound(wria_pkg::CFG_BOUND_B, b);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_operand(logic [4:0] op);
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 80) - 40;
            1: return (alu_model.bound_a < alu_model.bound_b) ?
                      alu_model.bound_a + $urandom_range(0, 20) :
                      alu_model.bound_b + $urandom_range(0, 20);
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            3: return (op >= wria_pkg::OP_SHL && op <= wria_pkg::OP_RSHR) ?
                      $urandom_range(0, 40) - 4 : $urandom_range(0, 300);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_run(int count);
        logic [4:0] op;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 40) == 0)
                op = $urandom_range(21, 31);
            else
                op = $urandom_range(0, 20);
            send_word(op, pick_operand(op), ($urandom_range(0, 3) != 0));
        end
    endtask

    initial
    begin
        alu_model   = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        out_ready   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = wria_pkg::CFG_BOUND_A;
        cfg_data    = '0;
        burst_left  = 0;
        stall_mode  = 0;
        cycle_count = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed words on the reset range [0, 11]
        send_word(wria_pkg::OP_CMP, 32'sd0, 1'b1);
        send_word(wria_pkg::OP_RMOD, 32'sd5, 1'b1);
        send_word(wria_pkg::OP_LOAD, 32'sh7fffffff, 1'b1);
        send_word(wria_pkg::OP_ADD, 32'sh80000000, 1'b1);
        send_word(wria_pkg::OP_SUB, 32'sd9, 1'b0);
        send_word(wria_pkg::OP_RSUB, -32'sd3, 1'b1);
        send_word(wria_pkg::OP_MUL, 32'sh7fffffff, 1'b1);
        send_word(wria_pkg::OP_DIV, 32'sd5, 1'b1);
        send_word(wria_pkg::OP_DIV, 32'sd4, 1'b1);
        send_word(wria_pkg::OP_RDIV, 32'sd7, 1'b1);
        send_word(wria_pkg::OP_MOD, 32'sd0, 1'b1);
        send_word(wria_pkg::OP_MOD, -32'sd4, 1'b1);
        send_word(wria_pkg::OP_RMOD, 32'sh80000000, 1'b1);
        send_word(wria_pkg::OP_XOR, 32'shffffffff, 1'b1);
        send_word(wria_pkg::OP_AND, 32'sh5555555a, 1'b1);
        send_word(wria_pkg::OP_OR, 32'sh80000003, 1'b1);
        send_word(wria_pkg::OP_SHL, 32'sd31, 1'b1);
        send_word(wria_pkg::OP_SHR, 32'sd32, 1'b1);
        send_word(wria_pkg::OP_SHL, -32'sd1, 1'b1);
        send_word(wria_pkg::OP_RSHL, 32'sh80000000, 1'b1);
        send_word(wria_pkg::OP_RSHR, -32'sd100, 1'b1);
        send_word(wria_pkg::OP_NOT, 32'sd0, 1'b1);
        send_word(wria_pkg::OP_NEG, 32'sd0, 1'b1);
        send_word(wria_pkg::OP_INC, 32'sd0, 1'b1);
        send_word(wria_pkg::OP_DEC, 32'sd0, 1'b1);
        send_word(5'd31, 32'sd0, 1'b1);
        random_run(250);

        write_bounds(32'sh80000000, 32'sh7fffffff);
        random_run(150);
        write_bounds(32'sd5, 32'sd5);
        random_run(120);
        write_bounds(32'sd100, -32'sd100);
        random_run(250);
        write_bounds(-32'sd7, 32'sd3);
        random_run(250);
        write_bounds(32'sh7fffff00, 32'sh7fffffff);
        random_run(150);
        write_bounds(32'sh80000000, 32'sh80000010);
        random_run(150);
        write_bounds($urandom(), $urandom());
        random_run(100);
        write_bounds($urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30);
        random_run(200);

        in_valid <= 1'b0;
        while (alu_model.pending_words.size() != 0)
            @(negedge clk);
        repeat (200) @(posedge clk);
        if (alu_model.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/wria_pkg.sv
hw/rtl/wria_div.sv
hw/rtl/wria_dp.sv
hw/rtl/wria_ctrl.sv
hw/rtl/wrapped_range_integer_alu_top.sv
bench/testbench.sv
